### src/jsu_pkg.sv
package jsu_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_end;
	} jsu_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       terminator;
	} jsu_out_t;

	typedef enum logic [2:0] {
		MODE_PLAIN = 3'd0,
		MODE_ESC   = 3'd1,
		MODE_HEX   = 3'd2,
		MODE_WAIT  = 3'd3,
		MODE_ESC2  = 3'd4,
		MODE_HEX2  = 3'd5
	} jsu_mode_t;

	// All results caused by one input byte: up to four UTF-8 bytes and a terminator.
	typedef struct packed {
		logic [4:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            term;
	} jsu_group_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      len;
	} jsu_utf8_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} jsu_hex_t;

	localparam logic [7:0]  CharBackslash = 8'h5C;
	localparam logic [7:0]  CharU         = 8'h75;
	localparam logic [5:0]  SurrHiTag     = 6'b110110;
	localparam logic [5:0]  SurrLoTag     = 6'b110111;
	localparam logic [20:0] SurrBase      = 21'h10000;
	localparam logic [2:0]  HexChars      = 3'd4;

	function automatic jsu_hex_t hex_digit(input logic [7:0] c);
		jsu_hex_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.val = 4'(c - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [7:0] esc_byte(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'h6E: r = 8'h0A;
			8'h74: r = 8'h09;
			8'h72: r = 8'h0D;
			8'h62: r = 8'h08;
			8'h66: r = 8'h0C;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic jsu_utf8_t utf8_encode(input logic [20:0] cp);
		jsu_utf8_t r;
		r = '0;
		if (cp < 21'h80) begin
			r.b[0] = cp[7:0];
			r.len  = 3'd1;
		end else if (cp < 21'h800) begin
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
			r.len  = 3'd2;
		end else if (cp < 21'h10000) begin
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
			r.len  = 3'd3;
		end else begin
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
			r.len  = 3'd4;
		end
		return r;
	endfunction

endpackage

### src/jsu_decode.sv
module jsu_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  jsu_pkg::jsu_in_t    item,
	input  logic                advance,
	output jsu_pkg::jsu_group_t grp
);
	import jsu_pkg::*;

	jsu_mode_t  mode_q, mode_n;
	logic [15:0] hv_q, hv_n;
	logic [2:0]  hc_q, hc_n;
	logic        hs_q, hs_n;
	logic [9:0]  hsb_q, hsb_n;

	jsu_hex_t    dig;
	logic [15:0] th_val;
	logic        th_stop;
	logic [2:0]  th_cnt;
	logic        th_done;
	logic [20:0] pair_cp;
	jsu_utf8_t   enc;
	logic        use_enc;
	logic [20:0] enc_cp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			hv_q   <= '0;
			hc_q   <= '0;
			hs_q   <= 1'b0;
			hsb_q  <= '0;
		end else if (advance) begin
			mode_q <= mode_n;
			hv_q   <= hv_n;
			hc_q   <= hc_n;
			hs_q   <= hs_n;
			hsb_q  <= hsb_n;
		end
	end

	always_comb begin
		dig     = hex_digit(item.in_byte);
		th_val  = hv_q;
		th_stop = hs_q;
		if (!hs_q) begin
			if (dig.ok) begin
				th_val = {hv_q[11:0], dig.val};
			end else begin
				th_stop = 1'b1;
			end
		end
		th_cnt  = hc_q + 3'd1;
		th_done = (th_cnt >= HexChars);
		pair_cp = {1'b0, hsb_q, th_val[9:0]} + SurrBase;
	end

	always_comb begin
		mode_n  = mode_q;
		hv_n    = hv_q;
		hc_n    = hc_q;
		hs_n    = hs_q;
		hsb_n   = hsb_q;
		grp     = '0;
		use_enc = 1'b0;
		enc_cp  = '0;
		case (mode_q)
			MODE_ESC, MODE_ESC2: begin
				mode_n = MODE_PLAIN;
				if (item.in_byte == CharU) begin
					mode_n = (mode_q == MODE_ESC2) ? MODE_HEX2 : MODE_HEX;
					hv_n   = '0;
					hc_n   = '0;
					hs_n   = 1'b0;
				end else begin
					grp.bytes[0] = esc_byte(item.in_byte);
					grp.cnt      = 3'd1;
				end
			end
			MODE_HEX: begin
				hv_n = th_val;
				hc_n = th_cnt;
				hs_n = th_stop;
				if (th_done) begin
					if (th_val[15:10] == SurrHiTag) begin
						hsb_n  = th_val[9:0];
						mode_n = MODE_WAIT;
					end else begin
						use_enc = 1'b1;
						enc_cp  = {5'd0, th_val};
						mode_n  = MODE_PLAIN;
					end
				end
			end
			MODE_WAIT: begin
				if (item.in_byte != CharBackslash) begin
					grp.bytes[0] = item.in_byte;
					grp.cnt      = 3'd1;
					mode_n       = MODE_PLAIN;
				end else begin
					mode_n = MODE_ESC2;
				end
			end
			MODE_HEX2: begin
				hv_n = th_val;
				hc_n = th_cnt;
				hs_n = th_stop;
				if (th_done) begin
					use_enc = 1'b1;
					enc_cp  = (th_val[15:10] == SurrLoTag) ? pair_cp : {5'd0, th_val};
					mode_n  = MODE_PLAIN;
				end
			end
			default: begin
				if (item.in_byte != CharBackslash) begin
					grp.bytes[0] = item.in_byte;
					grp.cnt      = 3'd1;
				end else begin
					mode_n = MODE_ESC;
				end
			end
		endcase

		enc = utf8_encode(enc_cp);
		if (use_enc) begin
			grp.bytes[3:0] = enc.b;
			grp.cnt        = enc.len;
		end

		if (item.string_end) begin
			grp.bytes[grp.cnt] = 8'h00;
			grp.cnt            = grp.cnt + 3'd1;
			grp.term           = 1'b1;
			mode_n             = MODE_PLAIN;
			hv_n               = '0;
			hc_n               = '0;
			hs_n               = 1'b0;
			hsb_n              = '0;
		end
	end

endmodule

### src/jsu_emit.sv
module jsu_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                grp_valid,
	input  jsu_pkg::jsu_group_t grp,
	output logic                advance,
	output logic                out_valid,
	input  logic                out_stall,
	output jsu_pkg::jsu_out_t   out_data
);
	import jsu_pkg::*;

	jsu_group_t grp_q;
	logic       valid_q;
	logic [2:0] idx_q;
	logic       last;
	logic       xfer;

	assign last      = (idx_q == grp_q.cnt - 3'd1);
	assign xfer      = valid_q && !out_stall;
	assign advance   = grp_valid && (!valid_q || (xfer && last));
	assign out_valid = valid_q;

	always_comb begin
		out_data.out_byte   = grp_q.bytes[idx_q];
		out_data.run_last   = last;
		out_data.terminator = grp_q.term && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= (grp.cnt != 3'd0);
			idx_q   <= '0;
		end else if (xfer) begin
			if (last) begin
				valid_q <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			grp_q <= grp;
		end
	end

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (idx_q < grp_q.cnt))
		else $error("result index beyond group size");

	a_term_is_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_data.terminator) |-> (out_data.run_last && out_data.out_byte == 8'h00))
		else $error("terminator is not the last zero byte");

	a_stall_holds_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_stall) |=> (valid_q && $stable(idx_q)))
		else $error("stalled result moved");

	a_advance_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (!valid_q || (xfer && last)))
		else $error("group overwritten before drained");

endmodule

### src/json_string_unescape_utf8.sv
// JSON string body unescaper with UTF-8 output.
// The byte channel (byte_valid, byte_stall, byte_data) takes one raw byte of a
// string body per transfer; string_end marks the final byte of a string.
// The text channel (text_valid, text_stall, text_data) gives one output byte per
// transfer, with run_last on the last byte caused by an input byte and
// terminator on the zero byte that closes each string.
// An input byte waits in an input register, is decoded in one pass into a group
// of up to five result bytes, and that group is held in a result register and
// drained one byte per cycle while text_stall is low. The first result of a
// byte appears once it has passed both registers. The block takes one input
// byte per cycle while each byte gives at most one result and text_stall is low;
// a byte that gives several results holds the byte channel until they drain
// through the single output port. Bytes that give no result (a backslash, hex
// digits) do not hold it. Reset clears both valid flags and returns the decoder
// to plain text mode. When the receiver stalls, the current result holds, the
// next group waits in the input register, and byte_stall rises once it is full.
module json_string_unescape_utf8 (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  jsu_pkg::jsu_in_t  byte_data,
	output logic              text_valid,
	input  logic              text_stall,
	output jsu_pkg::jsu_out_t text_data
);
	import jsu_pkg::*;

	logic       valid_s1;
	jsu_in_t    item_s1;
	logic       advance;
	logic       accept;
	jsu_group_t grp;

	assign byte_stall = valid_s1 && !advance;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_data;
		end
	end

	jsu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.grp     (grp)
	);

	jsu_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (valid_s1),
		.grp       (grp),
		.advance   (advance),
		.out_valid (text_valid),
		.out_stall (text_stall),
		.out_data  (text_data)
	);

endmodule
